// ===== rtl/power_factor_meter_macros.svh =====
// Assertion helpers for the power factor meter.
`ifndef POWER_FACTOR_METER_MACROS_SVH
`define POWER_FACTOR_METER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PFM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define PFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pfm_pkg.sv =====
package pfm_pkg;

	localparam int unsigned DELTA_MAX = 65535;
	localparam int unsigned PF_ONE_SHIFT = 15;
	// Nominal number of samples in a period; a period ends only on the last-sample mark.
	localparam int unsigned MAX_SAMPLES = 1024;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_PERIOD = 2'd1,
		ST_ZERO_APPARENT = 2'd2
	} pfm_status_t;

	typedef struct packed {
		logic signed [15:0] voltage_sample;
		logic signed [15:0] current_sample;
		logic [31:0] time_stamp;
		logic last_sample;
	} pfm_in_t;

	typedef struct packed {
		logic signed [31:0] real_power;
		logic [15:0] voltage_rms;
		logic [15:0] current_rms;
		logic [30:0] apparent_power;
		logic signed [15:0] power_factor;
		logic [1:0] status;
	} pfm_out_t;

	// Period totals handed from the accumulator to the back end.
	typedef struct packed {
		logic [31:0] period_sum;
		logic signed [63:0] power_area;
		logic [63:0] voltage_sq_area;
		logic [63:0] current_sq_area;
	} pfm_sums_t;

endpackage

// ===== rtl/power_factor_meter.sv =====
// Power factor meter. Samples are accepted one a cycle into a three-stage
// accumulator. After the sample marked last the input is held off while it
// drains through stages 1 and 2, and then until the back end, a shared
// shift-subtract divider and square-root unit, takes the period totals. The
// back end works through four 64-bit divisions, two square roots, a multiply
// and a load of the result register per period, or only the load for a zero
// period. A finished result waits in its own register, so a slow reader stalls
// the input only once a further period is also complete.
module power_factor_meter import pfm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  pfm_in_t in_data,
	output logic empty,
	input  logic pop,
	output pfm_out_t out_data
);
`include "power_factor_meter_macros.svh"

	logic busy, sums_valid, sums_taken, res_valid, acc;
	pfm_sums_t sums;

	assign full = busy || sums_valid;
	assign acc = push && !full;
	assign empty = !res_valid;

	pfm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(acc),
		.in_item(in_data), .busy(busy), .sums_valid(sums_valid), .sums(sums),
		.sums_taken(sums_taken)
	);

	pfm_back u_back (
		.clk(clk), .arst_n(arst_n), .sums_valid(sums_valid), .sums(sums),
		.sums_taken(sums_taken), .res_valid(res_valid), .res(out_data),
		.res_taken(pop && res_valid)
	);

	`PFM_ASSERT_IMP(a_no_push_full, clk, arst_n, sums_valid, full, "accepted while totals wait")
	`PFM_ASSERT_IMP(a_status_ok, clk, arst_n, !empty, out_data.status <= ST_ZERO_APPARENT, "bad status")
	`PFM_ASSERT_NEXT(a_take, clk, arst_n, sums_taken, !sums_valid, "totals not released")

endmodule

// ===== rtl/pfm_front.sv =====
// Front end: one sample a beat while not busy, trapezoid areas accumulated in a short pipeline.
module pfm_front import pfm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  pfm_in_t in_item,
	output logic busy,
	output logic sums_valid,
	output pfm_sums_t sums,
	input  logic sums_taken
);

	// Stage 1 registers: products of the pair and the clamped delta.
	logic v_s1, last_s1, pair_s1;
	logic signed [32:0] p_s1;
	logic [32:0] vv_s1, cc_s1;
	logic [15:0] dt_s1;

	// Stage 2 registers: areas times delta.
	logic v_s2, last_s2, pair_s2;
	logic signed [49:0] pa_s2;
	logic [48:0] va_s2, ca_s2;
	logic [15:0] dt_s2;

	logic signed [15:0] prev_v_q, prev_c_q;
	logic [31:0] prev_t_q;
	logic have_prev_q;
	pfm_sums_t acc_q;
	logic hold_q;

	logic [31:0] raw_dt;
	logic [32:0] new_period;
	logic ok_add;

	// Hold off new samples while a last sample drains or its totals wait.
	assign busy = hold_q || (v_s1 && last_s1) || (v_s2 && last_s2);
	assign sums_valid = hold_q;
	assign sums = acc_q;
	assign raw_dt = in_item.time_stamp - prev_t_q;

	// Sample history and stage 1 products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			have_prev_q <= 1'b0;
			prev_v_q <= '0;
			prev_c_q <= '0;
			prev_t_q <= '0;
		end else begin
			v_s1 <= in_valid;
			if (in_valid) begin
				if (in_item.last_sample) begin
					have_prev_q <= 1'b0;
					prev_v_q <= '0;
					prev_c_q <= '0;
					prev_t_q <= '0;
				end else begin
					have_prev_q <= 1'b1;
					prev_v_q <= in_item.voltage_sample;
					prev_c_q <= in_item.current_sample;
					prev_t_q <= in_item.time_stamp;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			last_s1 <= in_item.last_sample;
			pair_s1 <= have_prev_q;
			dt_s1 <= (raw_dt > 32'(DELTA_MAX)) ? 16'(DELTA_MAX) : raw_dt[15:0];
			p_s1 <= 33'(prev_v_q * prev_c_q) +
				33'(in_item.voltage_sample * in_item.current_sample);
			vv_s1 <= 33'($unsigned(32'(prev_v_q * prev_v_q))) +
				33'($unsigned(32'(in_item.voltage_sample * in_item.voltage_sample)));
			cc_s1 <= 33'($unsigned(32'(prev_c_q * prev_c_q))) +
				33'($unsigned(32'(in_item.current_sample * in_item.current_sample)));
		end
	end

	// Stage 2: multiply by delta.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			last_s2 <= last_s1;
			pair_s2 <= pair_s1;
			dt_s2 <= dt_s1;
			pa_s2 <= 50'(p_s1 * $signed({1'b0, dt_s1}));
			va_s2 <= 49'(vv_s1 * dt_s1);
			ca_s2 <= 49'(cc_s1 * dt_s1);
		end
	end

	assign new_period = {1'b0, acc_q.period_sum} + 33'(dt_s2);
	assign ok_add = pair_s2 && !new_period[32];

	// Stage 3: accumulate, and on the last sample hold for the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			hold_q <= 1'b0;
		end else begin
			if (hold_q && sums_taken) begin
				hold_q <= 1'b0;
				acc_q <= '0;
			end else if (v_s2) begin
				if (ok_add) begin
					acc_q.period_sum <= new_period[31:0];
					acc_q.power_area <= acc_q.power_area + 64'(pa_s2);
					acc_q.voltage_sq_area <= acc_q.voltage_sq_area + 64'(va_s2);
					acc_q.current_sq_area <= acc_q.current_sq_area + 64'(ca_s2);
				end
				if (last_s2) hold_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/pfm_back.sv =====
// Back end: divisions, square roots and power factor, one bit a cycle while not waiting for the result register.
module pfm_back import pfm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic sums_valid,
	input  pfm_sums_t sums,
	output logic sums_taken,
	output logic res_valid,
	output pfm_out_t res,
	input  logic res_taken
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DIVP = 9'b000000010,
		S_DIVV = 9'b000000100,
		S_SQV  = 9'b000001000,
		S_DIVC = 9'b000010000,
		S_SQC  = 9'b000100000,
		S_MUL  = 9'b001000000,
		S_PF   = 9'b010000000,
		S_OUT  = 9'b100000000
	} st_t;

	st_t st_q;
	logic [6:0] cnt_q;
	logic [63:0] num_q, rem_q, quo_q;
	logic [32:0] div_q;
	logic neg_q;
	logic [63:0] sx_q, sres_q, sbit_q;
	pfm_sums_t s_q;
	pfm_out_t r_q;
	pfm_out_t out_q;
	logic full_q;

	logic [64:0] rem_sh;
	logic [64:0] trial;
	logic [63:0] quo_nx;
	logic [63:0] rem_nx;
	logic [63:0] sum_rb;
	logic sq_take;
	logic [63:0] sres_nx;
	logic [31:0] abs_rp;
	logic load_out;

	assign sums_taken = sums_valid && st_q == S_IDLE;
	assign res_valid = full_q;
	assign res = out_q;
	assign load_out = st_q == S_OUT && (!full_q || res_taken);

	// Next divider and square-root step.
	assign rem_sh = {rem_q, num_q[63]};
	assign trial = rem_sh - {32'd0, div_q};
	assign quo_nx = {quo_q[62:0], !trial[64]};
	assign rem_nx = trial[64] ? rem_sh[63:0] : trial[63:0];
	assign sum_rb = sres_q + sbit_q;
	assign sq_take = sx_q >= sum_rb;
	assign sres_nx = sq_take ? (sres_q >> 1) + sbit_q : sres_q >> 1;
	assign abs_rp = r_q.real_power[31] ? 32'(-r_q.real_power) : r_q.real_power;

	// Result register: loaded when a period is finished, freed by a read beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			out_q <= '0;
		end else if (load_out) begin
			full_q <= 1'b1;
			out_q <= r_q;
		end else if (res_taken) begin
			full_q <= 1'b0;
		end
	end

	// Sequencer for the shared divider and square-root unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			div_q <= '0;
			neg_q <= 1'b0;
			sx_q <= '0;
			sres_q <= '0;
			sbit_q <= '0;
			s_q <= '0;
			r_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (sums_taken) begin
						s_q <= sums;
						if (sums.period_sum == 32'd0) begin
							r_q <= '{status: ST_ZERO_PERIOD, default: '0};
							st_q <= S_OUT;
						end else begin
							r_q <= '0;
							neg_q <= sums.power_area[63];
							num_q <= sums.power_area[63] ? 64'(-sums.power_area)
								: sums.power_area;
							div_q <= {sums.period_sum, 1'b0};
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= 7'd64;
							st_q <= S_DIVP;
						end
					end
				end
				S_DIVP, S_DIVV, S_DIVC, S_PF: begin
					// Restoring division, one quotient bit per cycle.
					if (cnt_q != 7'd1) begin
						num_q <= {num_q[62:0], 1'b0};
						rem_q <= rem_nx;
						quo_q <= quo_nx;
						cnt_q <= cnt_q - 7'd1;
					end else begin
						case (st_q)
							S_DIVP: begin
								r_q.real_power <= neg_q ? -32'(quo_nx) : 32'(quo_nx);
								num_q <= s_q.voltage_sq_area;
								rem_q <= '0;
								quo_q <= '0;
								cnt_q <= 7'd64;
								st_q <= S_DIVV;
							end
							S_DIVV: begin
								sx_q <= quo_nx;
								sres_q <= '0;
								sbit_q <= 64'd1 << 62;
								cnt_q <= 7'd32;
								st_q <= S_SQV;
							end
							S_DIVC: begin
								sx_q <= quo_nx;
								sres_q <= '0;
								sbit_q <= 64'd1 << 62;
								cnt_q <= 7'd32;
								st_q <= S_SQC;
							end
							default: begin
								if (quo_nx > 64'd32767)
									r_q.power_factor <= neg_q ? 16'sh8000 : 16'sh7FFF;
								else if (neg_q)
									r_q.power_factor <= -quo_nx[15:0];
								else
									r_q.power_factor <= quo_nx[15:0];
								st_q <= S_OUT;
							end
						endcase
					end
				end
				S_SQV, S_SQC: begin
					// Bit-pair square root, one result bit per cycle.
					if (cnt_q != 7'd1) begin
						if (sq_take) sx_q <= sx_q - sum_rb;
						sres_q <= sres_nx;
						sbit_q <= sbit_q >> 2;
						cnt_q <= cnt_q - 7'd1;
					end else if (st_q == S_SQV) begin
						r_q.voltage_rms <= sres_nx[15:0];
						num_q <= s_q.current_sq_area;
						div_q <= {s_q.period_sum, 1'b0};
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 7'd64;
						st_q <= S_DIVC;
					end else begin
						r_q.current_rms <= sres_nx[15:0];
						st_q <= S_MUL;
					end
				end
				S_MUL: begin
					r_q.apparent_power <= 31'(r_q.voltage_rms * r_q.current_rms);
					if (r_q.voltage_rms == 0 || r_q.current_rms == 0) begin
						r_q.status <= ST_ZERO_APPARENT;
						st_q <= S_OUT;
					end else begin
						neg_q <= r_q.real_power[31];
						num_q <= {17'd0, abs_rp, 15'd0};
						div_q <= 33'(r_q.voltage_rms * r_q.current_rms);
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 7'd64;
						st_q <= S_PF;
					end
				end
				S_OUT: begin
					// Wait for the result register to be free.
					if (load_out) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
